// File: hw/rtl/ast_pkg.sv
`timescale 1ns / 1ps

package ast_pkg;

	localparam int TEXT_CAPACITY_DEF = 32;
	localparam int POSITION_BITS_DEF = 16;
	localparam int NUM_KW            = 34;
	localparam int KW_MAXLEN         = 17;
	localparam int KIND_W            = 6;

	localparam logic [KIND_W-1:0] K_EOF      = 6'd0;
	localparam logic [KIND_W-1:0] K_INVALID  = 6'd1;
	localparam logic [KIND_W-1:0] K_STRING   = 6'd2;
	localparam logic [KIND_W-1:0] K_NUMBER   = 6'd3;
	localparam logic [KIND_W-1:0] K_HEADER   = 6'd4;
	localparam logic [KIND_W-1:0] K_SEMI     = 6'd5;
	localparam logic [KIND_W-1:0] K_COLON    = 6'd6;
	localparam logic [KIND_W-1:0] K_LBRACE   = 6'd7;
	localparam logic [KIND_W-1:0] K_RBRACE   = 6'd8;
	localparam logic [KIND_W-1:0] K_HASH     = 6'd9;
	localparam logic [KIND_W-1:0] K_DOLLAR   = 6'd10;
	localparam logic [KIND_W-1:0] K_KEYWORD0 = 6'd11;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_SP     = 8'h20;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_DASH   = 8'h2D;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_USCORE = 8'h5F;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;

	localparam logic [8*KW_MAXLEN-1:0] KW_STR [NUM_KW] = '{
		"globals", {"global", "_pointers"}, "args", {"ptr", "_args"}, "locals",
		{"local", "_pointers"}, "LoadLocalI64", "PushI64", {"LessThanI64", "_RI"},
		"LessThanI64", {"GreaterThanI64", "_RI"}, "GreaterThanI64", {"EqualsI64", "_RI"},
		"EqualsI64", "NotEqualsI64", "NotI64", "JumpIfFalse", "Return",
		{"AddI64", "_RI"}, "AddI64", "SubI64_RI", "SubI64", {"MulI64", "_RI"}, "MulI64",
		{"DivI64", "_RI"}, "DivI64", {"ModI64", "_RI"}, "ModI64", "Call", "PrintTopStackI64",
		"PushLiteralString", "ConcatStrings", "PrintString", "Exit"
	};

	localparam logic [4:0] KW_LEN [NUM_KW] = '{
		5'd7, 5'd15, 5'd4, 5'd8, 5'd6, 5'd14, 5'd12, 5'd7, 5'd14, 5'd11,
		5'd17, 5'd14, 5'd12, 5'd9, 5'd12, 5'd6, 5'd11, 5'd6, 5'd9, 5'd6,
		5'd9, 5'd6, 5'd9, 5'd6, 5'd9, 5'd6, 5'd9, 5'd6, 5'd4, 5'd16,
		5'd17, 5'd13, 5'd11, 5'd4
	};

	// character of keyword k at pos, 0 past its end
	function automatic logic [7:0] kw_char(input logic [5:0] k, input logic [5:0] pos);
		logic [7:0] c;
		int sh;
		c  = CH_NUL;
		sh = 0;
		if (k < 6'(NUM_KW)) begin
			if (pos < 6'(KW_LEN[k])) begin
				sh = 8 * (int'(KW_LEN[k]) - 1 - int'(pos));
				c  = KW_STR[k][sh +: 8];
			end
		end
		return c;
	endfunction

	typedef struct packed {
		logic load;
		logic step;
		logic beat;
		logic flush;
	} ast_cmd_t;

	typedef struct packed {
		logic emit;
		logic requeue;
		logic rq_held;
		logic em_last;
		logic beat_ok;
		logic out_free;
		logic pend_valid;
	} ast_stat_t;

endpackage

// File: hw/rtl/ast_datapath.sv
`timescale 1ns / 1ps

module ast_datapath #(
	parameter int TEXT_CAPACITY = 32,
	parameter int POSITION_BITS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  ast_pkg::ast_cmd_t        cmd,
	output ast_pkg::ast_stat_t       stat,
	input  logic [7:0]               in_byte,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [5:0]               out_kind,
	output logic [POSITION_BITS-1:0] out_line,
	output logic [POSITION_BITS-1:0] out_col,
	output logic [4:0]               out_len,
	output logic [7:0]               out_char,
	output logic [4:0]               out_pos,
	output logic                     out_tdone,
	output logic                     out_run
);
	import ast_pkg::*;

	localparam int CNT_W = $clog2(TEXT_CAPACITY);
	localparam int P     = POSITION_BITS;

	typedef enum logic [3:0] {
		M_IDLE, M_DASH1, M_DASH2, M_STR, M_STR_ESC, M_WORD, M_NUM, M_SLASH, M_COMMENT
	} mode_t;

	mode_t              mode_q, mode_n;
	logic [P-1:0]       line_q, col_q, tok_l_q, tok_c_q;
	logic [P-1:0]       line_n, col_n, tok_l_n, tok_c_n;
	logic [P-1:0]       col_inc, col_inc2;
	logic [CNT_W-1:0]   cnt_q, cnt_n, k_q;
	logic [7:0]         store_q [TEXT_CAPACITY];
	logic [NUM_KW-1:0]  mask_q, mask_n, mask_new, mask_upd;
	logic [7:0]         cur_q;
	logic [KIND_W-1:0]  em_kind_q, kind, word_kind;
	logic [CNT_W-1:0]   em_n_q;
	logic               em_eof_q, em_redash_q, rq_q;
	logic               emit, use_txt, eof, redash, requeue;
	logic               wr_en, hdr_wr;
	logic [CNT_W-1:0]   wr_idx;
	logic [7:0]         wr_data;
	logic               is_sep, is_digit, is_wstart, is_punct;
	logic [KIND_W-1:0]  pkind;
	logic               em_last;
	logic [7:0]         b;

	logic               pend_valid_q;
	logic [KIND_W-1:0]  pend_kind_q;
	logic [P-1:0]       pend_line_q, pend_col_q;
	logic [4:0]         pend_len_q, pend_pos_q;
	logic [7:0]         pend_char_q;
	logic               pend_tdone_q;

	function automatic logic [P-1:0] sat_inc(input logic [P-1:0] v);
		return (&v) ? v : v + 1'b1;
	endfunction

	assign col_inc  = sat_inc(col_q);
	assign col_inc2 = sat_inc(col_inc);
	assign b        = cur_q;

	always_comb begin
		is_digit  = (b >= 8'h30) && (b <= 8'h39);
		is_wstart = ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A)) ||
			(b == CH_USCORE);
		is_sep = (b == CH_SP) || (b == CH_TAB) || (b == CH_NL) || (b == CH_NUL) ||
			(b == CH_SEMI) || (b == CH_COLON) || (b == CH_LBRACE) || (b == CH_RBRACE) ||
			(b == CH_HASH) || (b == CH_DOLLAR) || (b == CH_SLASH) || (b == CH_QUOTE) ||
			(b == CH_DASH);
		is_punct = 1'b1;
		pkind    = K_INVALID;
		case (b)
			CH_SEMI:   pkind = K_SEMI;
			CH_COLON:  pkind = K_COLON;
			CH_LBRACE: pkind = K_LBRACE;
			CH_RBRACE: pkind = K_RBRACE;
			CH_HASH:   pkind = K_HASH;
			CH_DOLLAR: pkind = K_DOLLAR;
			default:   is_punct = 1'b0;
		endcase
	end

	// incremental keyword match, one char per stored byte
	always_comb begin
		word_kind = K_INVALID;
		for (int k = 0; k < NUM_KW; k++) begin
			mask_new[k] = (kw_char(6'(k), 6'd0) == b);
			mask_upd[k] = mask_q[k] & (kw_char(6'(k), 6'(cnt_q)) == b);
		end
		for (int k = NUM_KW - 1; k >= 0; k--) begin
			if (mask_q[k] && (6'(KW_LEN[k]) == 6'(cnt_q)))
				word_kind = K_KEYWORD0 + 6'(k);
		end
	end

	always_comb begin
		mode_n  = mode_q;
		line_n  = line_q;
		col_n   = col_q;
		tok_l_n = tok_l_q;
		tok_c_n = tok_c_q;
		cnt_n   = cnt_q;
		mask_n  = mask_q;
		wr_en   = 1'b0;
		wr_idx  = '0;
		wr_data = b;
		hdr_wr  = 1'b0;
		emit    = 1'b0;
		use_txt = 1'b0;
		kind    = K_INVALID;
		eof     = 1'b0;
		redash  = 1'b0;
		requeue = 1'b0;
		case (mode_q)
			M_IDLE: begin
				if (b == CH_NL) begin
					line_n = sat_inc(line_q);
					col_n  = P'(1);
				end else if (b == CH_SP || b == CH_TAB) begin
					col_n = col_inc;
				end else if (b == CH_NUL) begin
					emit = 1'b1;
					kind = K_EOF;
					eof  = 1'b1;
				end else begin
					tok_l_n = line_q;
					tok_c_n = col_q;
					col_n   = col_inc;
					cnt_n   = '0;
					if (b == CH_DASH) begin
						mode_n = M_DASH1;
					end else if (b == CH_QUOTE) begin
						mode_n = M_STR;
					end else if (b == CH_SLASH) begin
						mode_n = M_SLASH;
					end else begin
						wr_en = 1'b1;
						cnt_n = CNT_W'(1);
						if (is_wstart) begin
							mask_n = mask_new;
							mode_n = M_WORD;
						end else if (is_digit) begin
							mode_n = M_NUM;
						end else begin
							emit    = 1'b1;
							use_txt = 1'b1;
							kind    = is_punct ? pkind : K_INVALID;
						end
					end
				end
			end
			M_DASH1, M_DASH2: begin
				if (b == CH_DASH && mode_q == M_DASH1) begin
					mode_n = M_DASH2;
				end else if (b == CH_DASH) begin
					col_n   = col_inc2;
					hdr_wr  = 1'b1;
					cnt_n   = CNT_W'(3);
					emit    = 1'b1;
					use_txt = 1'b1;
					kind    = K_HEADER;
				end else begin
					wr_en   = 1'b1;
					wr_data = CH_DASH;
					cnt_n   = CNT_W'(1);
					emit    = 1'b1;
					use_txt = 1'b1;
					redash  = (mode_q == M_DASH2);
					requeue = 1'b1;
				end
			end
			M_STR, M_STR_ESC: begin
				col_n = col_inc;
				if (b == CH_NUL) begin
					emit    = 1'b1;
					requeue = 1'b1;
				end else if (mode_q == M_STR && b == CH_QUOTE) begin
					emit    = 1'b1;
					use_txt = 1'b1;
					kind    = K_STRING;
				end else if (mode_q == M_STR && b == CH_BSLASH) begin
					mode_n = M_STR_ESC;
				end else begin
					wr_en  = 1'b1;
					wr_idx = cnt_q;
					cnt_n  = cnt_q + 1'b1;
					mode_n = M_STR;
					if (({1'b0, cnt_q} + 1'b1) >= (CNT_W + 1)'(TEXT_CAPACITY - 1))
						emit = 1'b1;
				end
			end
			M_WORD, M_NUM: begin
				if ((mode_q == M_WORD && !is_sep) || (mode_q == M_NUM && is_digit)) begin
					col_n = col_inc;
					if (cnt_q < CNT_W'(TEXT_CAPACITY - 1)) begin
						wr_en  = 1'b1;
						wr_idx = cnt_q;
						cnt_n  = cnt_q + 1'b1;
						mask_n = mask_upd;
					end else begin
						emit    = 1'b1;
						use_txt = 1'b1;
					end
				end else begin
					emit    = 1'b1;
					use_txt = 1'b1;
					requeue = 1'b1;
				end
				kind = (mode_q == M_WORD) ? word_kind : K_NUMBER;
			end
			M_SLASH: begin
				if (b == CH_SLASH) begin
					col_n  = col_inc;
					mode_n = M_COMMENT;
				end else begin
					wr_en   = 1'b1;
					wr_data = CH_SLASH;
					cnt_n   = CNT_W'(1);
					emit    = 1'b1;
					use_txt = 1'b1;
					requeue = 1'b1;
				end
			end
			M_COMMENT: begin
				if (b == CH_NL || b == CH_NUL) begin
					mode_n  = M_IDLE;
					requeue = 1'b1;
				end else begin
					col_n = col_inc;
				end
			end
			default: begin
				mode_n  = M_IDLE;
				requeue = 1'b1;
			end
		endcase
	end

	assign em_last = ({1'b0, k_q} + 1'b1) >= {1'b0, em_n_q};

	always_comb begin
		stat.emit       = emit;
		stat.requeue    = requeue;
		stat.rq_held    = rq_q;
		stat.em_last    = em_last;
		stat.out_free   = !out_valid || out_ready;
		stat.beat_ok    = !pend_valid_q || !out_valid || out_ready;
		stat.pend_valid = pend_valid_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= M_IDLE;
			cnt_q        <= '0;
			line_q       <= P'(1);
			col_q        <= P'(1);
			tok_l_q      <= P'(1);
			tok_c_q      <= P'(1);
			k_q          <= '0;
			pend_valid_q <= 1'b0;
			out_valid    <= 1'b0;
		end else begin
			if (cmd.step) begin
				mode_q  <= mode_n;
				line_q  <= line_n;
				col_q   <= col_n;
				tok_l_q <= tok_l_n;
				tok_c_q <= tok_c_n;
				cnt_q   <= cnt_n;
			end
			if (cmd.beat) begin
				if (em_last) begin
					k_q   <= '0;
					cnt_q <= '0;
					if (em_redash_q) begin
						col_q  <= col_inc;
						mode_q <= M_DASH1;
					end else begin
						mode_q <= M_IDLE;
					end
					if (em_eof_q) begin
						line_q  <= P'(1);
						col_q   <= P'(1);
						tok_l_q <= P'(1);
						tok_c_q <= P'(1);
					end else begin
						tok_l_q <= line_q;
						tok_c_q <= col_q;
					end
				end else begin
					k_q <= k_q + 1'b1;
				end
			end
			if ((cmd.beat && pend_valid_q) || cmd.flush)
				out_valid <= 1'b1;
			else if (out_ready)
				out_valid <= 1'b0;
			if (cmd.beat)
				pend_valid_q <= 1'b1;
			else if (cmd.flush)
				pend_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load)
			cur_q <= in_byte;
		if (cmd.step) begin
			mask_q <= mask_n;
			rq_q   <= requeue;
			if (wr_en)
				store_q[wr_idx] <= wr_data;
			if (hdr_wr) begin
				store_q[CNT_W'(0)] <= CH_DASH;
				store_q[CNT_W'(1)] <= CH_DASH;
				store_q[CNT_W'(2)] <= CH_DASH;
			end
			if (emit) begin
				em_kind_q   <= kind;
				em_n_q      <= use_txt ? cnt_n : '0;
				em_eof_q    <= eof;
				em_redash_q <= redash;
			end
		end
		if (cmd.beat) begin
			pend_kind_q  <= em_kind_q;
			pend_line_q  <= tok_l_q;
			pend_col_q   <= tok_c_q;
			pend_len_q   <= 5'(em_n_q);
			pend_char_q  <= (em_n_q == '0) ? CH_NUL : store_q[k_q];
			pend_pos_q   <= 5'(k_q);
			pend_tdone_q <= em_last;
		end
		if ((cmd.beat && pend_valid_q) || cmd.flush) begin
			out_kind  <= pend_kind_q;
			out_line  <= pend_line_q;
			out_col   <= pend_col_q;
			out_len   <= pend_len_q;
			out_char  <= pend_char_q;
			out_pos   <= pend_pos_q;
			out_tdone <= pend_tdone_q;
			out_run   <= cmd.flush;
		end
	end

endmodule

// File: hw/rtl/ast_ctrl.sv
`timescale 1ns / 1ps

module ast_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  ast_pkg::ast_stat_t stat,
	output ast_pkg::ast_cmd_t  cmd
);
	import ast_pkg::*;

	typedef enum logic [1:0] {S_IN, S_STEP, S_EMIT, S_FLUSH} state_t;

	state_t state_q, state_n;

	always_comb begin
		state_n   = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		case (state_q)
			S_IN: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
				if (in_valid)
					state_n = S_STEP;
			end
			S_STEP: begin
				cmd.step = 1'b1;
				if (stat.emit)
					state_n = S_EMIT;
				else if (stat.requeue)
					state_n = S_STEP;
				else
					state_n = stat.pend_valid ? S_FLUSH : S_IN;
			end
			S_EMIT: begin
				cmd.beat = stat.beat_ok;
				if (stat.beat_ok && stat.em_last)
					state_n = stat.rq_held ? S_STEP : S_FLUSH;
			end
			S_FLUSH: begin
				cmd.flush = stat.out_free;
				if (stat.out_free)
					state_n = S_IN;
			end
			default: state_n = S_IN;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IN;
		else
			state_q <= state_n;
	end

endmodule

// File: hw/rtl/assembly_source_tokenizer.sv
`timescale 1ns / 1ps
// A byte is taken, then scanned in the next cycle; a token then leaves one beat per cycle
// while m_tready allows, one beat per text character (a single beat if it has no text), and
// the byte's last beat is held, then released by a flush. One byte is taken at a time: the
// next waits for its scan, any rescan of it (after a closed token or comment), its beats and
// that release, paced by the single-step scanner and beat emitter; m_tready low stalls them.
// Reset (arst_n low, async): line, column and token start at 1, scanner idle, no beats held.

module assembly_source_tokenizer #(
	parameter int TEXT_CAPACITY = ast_pkg::TEXT_CAPACITY_DEF,
	parameter int POSITION_BITS = ast_pkg::POSITION_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [7:0] s_tdata, // text_byte
	output logic m_tvalid,
	input  logic m_tready,
	// token_kind, start_line, start_column, text_length, text_char, char_position, zero pad
	output logic [((24 + 2 * POSITION_BITS + 7) / 8) * 8 - 1:0] m_tdata,
	output logic m_tlast, // run_done
	output logic m_tuser  // token_done
);
	import ast_pkg::*;

	localparam int P      = POSITION_BITS;
	localparam int OFF_LN = 6;
	localparam int OFF_CL = OFF_LN + P;
	localparam int OFF_LE = OFF_CL + P;
	localparam int OFF_CH = OFF_LE + 5;
	localparam int OFF_PS = OFF_CH + 8;

	ast_cmd_t  cmd;
	ast_stat_t stat;

	logic [5:0]   o_kind;
	logic [P-1:0] o_line, o_col;
	logic [4:0]   o_len, o_pos;
	logic [7:0]   o_char;

	ast_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	ast_datapath #(
		.TEXT_CAPACITY (TEXT_CAPACITY),
		.POSITION_BITS (POSITION_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_byte   (s_tdata),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_kind  (o_kind),
		.out_line  (o_line),
		.out_col   (o_col),
		.out_len   (o_len),
		.out_char  (o_char),
		.out_pos   (o_pos),
		.out_tdone (m_tuser),
		.out_run   (m_tlast)
	);

	always_comb begin
		m_tdata                  = '0;
		m_tdata[5:0]             = o_kind;
		m_tdata[OFF_LN +: P]     = o_line;
		m_tdata[OFF_CL +: P]     = o_col;
		m_tdata[OFF_LE +: 5]     = o_len;
		m_tdata[OFF_CH +: 8]     = o_char;
		m_tdata[OFF_PS +: 5]     = o_pos;
	end

	a_run_ends_token: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tuser)
		else $error("run ends mid-token");

	a_ready_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !stat.pend_valid)
		else $error("input taken with a beat still held");

	a_one_byte_at_once: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second byte taken before scan");

endmodule
